### rtl/core/h2d_pkg.sv
// Shared types and constants of the HTTP/2 receive deframer.
package h2d_pkg;

	localparam int PrefaceBytes = 24;
	localparam int FrameLimit   = 16384;

	typedef enum logic [1:0] {
		PH_PREFACE = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_DEAD    = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		EV_PAYLOAD      = 4'd0,
		EV_FRAME_DONE   = 4'd1,
		EV_SETTINGS_ACK = 4'd2,
		EV_ACK_SEEN     = 4'd3,
		EV_PONG         = 4'd4,
		EV_HDRS_DONE    = 4'd5,
		EV_HDRS_RESP    = 4'd6,
		EV_PREFACE_OK   = 4'd7,
		EV_BAD_PREFACE  = 4'd8,
		EV_TOO_LONG     = 4'd9,
		EV_HDRS_ZERO    = 4'd10,
		EV_CONT_MISM    = 4'd11,
		EV_BAD_PING     = 4'd12
	} event_t;

	localparam logic [7:0] TypeHeaders  = 8'h01;
	localparam logic [7:0] TypeSettings = 8'h04;
	localparam logic [7:0] TypePing     = 8'h06;
	localparam logic [7:0] TypeCont     = 8'h09;
	localparam logic [7:0] FlagAck      = 8'h01;
	localparam logic [7:0] FlagEndStrm  = 8'h01;
	localparam logic [7:0] FlagEndHdrs  = 8'h04;
	localparam logic [15:0] SetMaxStreams = 16'h0003;
	localparam logic [15:0] SetWindow     = 16'h0004;
	localparam logic [31:0] MaxStreamsRst = 32'd100;
	localparam logic [31:0] WindowRst     = 32'd65535;

	typedef struct packed {
		logic [3:0]  event_res;
		logic [7:0]  frame_type;
		logic [7:0]  frame_flags;
		logic [30:0] stream_id;
		logic [23:0] frame_length;
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic [13:0] payload_offset;
		logic        commit;          // back end applies pending settings
		logic        set_entry;       // a full settings entry completed
		logic [15:0] entry_id;
		logic [31:0] entry_value;
		logic        clear_pending;   // header end discards pending settings
		logic        emit;            // a result word goes out
	} cmd_t;

	function automatic logic [7:0] preface_byte(input logic [4:0] idx);
		case (idx)
			5'd0: preface_byte = 8'h50;  5'd1: preface_byte = 8'h52;
			5'd2: preface_byte = 8'h49;  5'd3: preface_byte = 8'h20;
			5'd4: preface_byte = 8'h2A;  5'd5: preface_byte = 8'h20;
			5'd6: preface_byte = 8'h48;  5'd7: preface_byte = 8'h54;
			5'd8: preface_byte = 8'h54;  5'd9: preface_byte = 8'h50;
			5'd10: preface_byte = 8'h2F; 5'd11: preface_byte = 8'h32;
			5'd12: preface_byte = 8'h2E; 5'd13: preface_byte = 8'h30;
			5'd14: preface_byte = 8'h0D; 5'd15: preface_byte = 8'h0A;
			5'd16: preface_byte = 8'h0D; 5'd17: preface_byte = 8'h0A;
			5'd18: preface_byte = 8'h53; 5'd19: preface_byte = 8'h4D;
			5'd20: preface_byte = 8'h0D; 5'd21: preface_byte = 8'h0A;
			5'd22: preface_byte = 8'h0D; 5'd23: preface_byte = 8'h0A;
			default: preface_byte = 8'h00;
		endcase
	endfunction

	function automatic logic [3:0] frame_action(input logic [7:0] ftype,
		input logic [7:0] flags);
		case (ftype)
			TypeSettings: frame_action = (flags & FlagAck) != 8'd0 ?
				EV_ACK_SEEN : EV_SETTINGS_ACK;
			TypeHeaders, TypeCont: begin
				if ((flags & FlagEndHdrs) != 8'd0)
					frame_action = (flags & FlagEndStrm) != 8'd0 ?
						EV_HDRS_RESP : EV_HDRS_DONE;
				else
					frame_action = EV_FRAME_DONE;
			end
			TypePing: frame_action = (flags & FlagAck) != 8'd0 ?
				EV_FRAME_DONE : EV_PONG;
			default: frame_action = EV_FRAME_DONE;
		endcase
	endfunction

endpackage

### rtl/core/h2d_if.sv
// Valid/ready channel interfaces of the deframer.
interface h2d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	modport source(output valid, output data_byte, input ready);
	modport sink(input valid, input data_byte, output ready);
endinterface

interface h2d_cfg_if;
	logic        valid;
	logic        ready;
	logic [14:0] max_frame_len;
	modport source(output valid, output max_frame_len, input ready);
	modport sink(input valid, input max_frame_len, output ready);
endinterface

interface h2d_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  event_res;
	logic [7:0]  frame_type;
	logic [7:0]  frame_flags;
	logic [30:0] stream_id;
	logic [23:0] frame_length;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic [13:0] payload_offset;
	logic [31:0] peer_max_streams;
	logic [31:0] peer_window;
	modport source(output valid, output event_res, output frame_type,
		output frame_flags, output stream_id, output frame_length,
		output payload_valid, output payload_byte, output payload_offset,
		output peer_max_streams, output peer_window, input ready);
	modport sink(input valid, input event_res, input frame_type,
		input frame_flags, input stream_id, input frame_length,
		input payload_valid, input payload_byte, input payload_offset,
		input peer_max_streams, input peer_window, output ready);
endinterface

### rtl/core/h2d_front.sv
// Front end: preface match, header split, checks and settings entry parse.
module h2d_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [7:0]        in_byte,
	input  logic [14:0]       max_frame_len,
	output logic              take,
	input  logic              q_full,
	output h2d_pkg::cmd_t     cmd
);

	h2d_pkg::phase_t phase_q, phase_nx;
	logic [4:0]  preface_pos_q;
	logic        preface_bad_q;
	logic [3:0]  header_pos_q;
	logic [23:0] cur_length_q;
	logic [7:0]  cur_type_q, cur_flags_q;
	logic [30:0] cur_stream_q;
	logic [14:0] payload_pos_q;
	logic [30:0] header_stream_q;
	logic [2:0]  entry_pos_q;
	logic [15:0] entry_id_q;
	logic [31:0] entry_value_q;

	logic [23:0] len_n;
	logic [30:0] strm_n;
	logic [14:0] limit;
	logic        bad_n;
	logic [14:0] pp_n;
	logic        is_set;

	assign take = in_valid && !q_full;
	assign limit = max_frame_len > 15'(h2d_pkg::FrameLimit) ?
		15'(h2d_pkg::FrameLimit) : max_frame_len;
	// The length bytes are complete before the last header byte arrives.
	assign len_n  = cur_length_q;
	assign strm_n = {cur_stream_q[30:8], in_byte};
	assign bad_n  = preface_bad_q || in_byte != h2d_pkg::preface_byte(preface_pos_q);
	assign pp_n   = payload_pos_q + 15'd1;
	assign is_set = cur_type_q == h2d_pkg::TypeSettings &&
		(cur_flags_q & h2d_pkg::FlagAck) == 8'd0;

	always_comb begin
		phase_nx = phase_q;
		if (take) begin
			case (phase_q)
				h2d_pkg::PH_PREFACE:
					if (preface_pos_q == 5'(h2d_pkg::PrefaceBytes - 1))
						phase_nx = bad_n ? h2d_pkg::PH_DEAD : h2d_pkg::PH_HEADER;
				h2d_pkg::PH_HEADER:
					if (header_pos_q == 4'd8) begin
						if (cmd.event_res >= 4'(h2d_pkg::EV_TOO_LONG))
							phase_nx = h2d_pkg::PH_DEAD;
						else if (len_n != 24'd0)
							phase_nx = h2d_pkg::PH_PAYLOAD;
					end
				h2d_pkg::PH_PAYLOAD:
					if (24'(pp_n) >= cur_length_q) phase_nx = h2d_pkg::PH_HEADER;
				default: phase_nx = h2d_pkg::PH_DEAD;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.entry_id = entry_id_q;
		cmd.entry_value = {entry_value_q[23:0], in_byte};
		cmd.frame_type = cur_type_q;
		cmd.frame_flags = cur_flags_q;
		cmd.stream_id = cur_stream_q;
		cmd.frame_length = cur_length_q;
		case (phase_q)
			h2d_pkg::PH_PREFACE: begin
				cmd.frame_type = '0; cmd.frame_flags = '0;
				cmd.stream_id = '0; cmd.frame_length = '0;
				cmd.emit = preface_pos_q == 5'(h2d_pkg::PrefaceBytes - 1);
				cmd.event_res = bad_n ? h2d_pkg::EV_BAD_PREFACE : h2d_pkg::EV_PREFACE_OK;
			end
			h2d_pkg::PH_HEADER: begin
				cmd.stream_id = strm_n;
				cmd.frame_length = len_n;
				cmd.clear_pending = header_pos_q == 4'd8;
				if (len_n > 24'(limit)) cmd.event_res = h2d_pkg::EV_TOO_LONG;
				else if (cur_type_q == h2d_pkg::TypeHeaders && strm_n == 31'd0)
					cmd.event_res = h2d_pkg::EV_HDRS_ZERO;
				else if (cur_type_q == h2d_pkg::TypeCont && strm_n != header_stream_q)
					cmd.event_res = h2d_pkg::EV_CONT_MISM;
				else if (cur_type_q == h2d_pkg::TypePing && len_n != 24'd8)
					cmd.event_res = h2d_pkg::EV_BAD_PING;
				else cmd.event_res = h2d_pkg::frame_action(cur_type_q, cur_flags_q);
				cmd.emit = header_pos_q == 4'd8 &&
					(cmd.event_res >= 4'(h2d_pkg::EV_TOO_LONG) || len_n == 24'd0);
				// Zero-length SETTINGS commit nothing pending, so no commit flag.
			end
			h2d_pkg::PH_PAYLOAD: begin
				cmd.emit = 1'b1;
				cmd.payload_valid = 1'b1;
				cmd.payload_byte = in_byte;
				cmd.payload_offset = payload_pos_q[13:0];
				cmd.set_entry = is_set && entry_pos_q == 3'd5;
				if (24'(pp_n) >= cur_length_q) begin
					cmd.event_res = h2d_pkg::frame_action(cur_type_q, cur_flags_q);
					// The entry position counts the payload modulo 6, so the length
					// is whole entries exactly when the last byte closes an entry.
					cmd.commit = is_set && entry_pos_q == 3'd5;
				end else
					cmd.event_res = h2d_pkg::EV_PAYLOAD;
			end
			default: cmd.emit = 1'b0;
		endcase
		cmd.emit = cmd.emit && take;
		cmd.set_entry = cmd.set_entry && take;
		cmd.commit = cmd.commit && take;
		cmd.clear_pending = cmd.clear_pending && take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= h2d_pkg::PH_PREFACE;
			preface_pos_q <= '0;
			preface_bad_q <= 1'b0;
			header_pos_q <= '0;
			cur_length_q <= '0;
			cur_type_q <= '0;
			cur_flags_q <= '0;
			cur_stream_q <= '0;
			payload_pos_q <= '0;
			header_stream_q <= '0;
			entry_pos_q <= '0;
			entry_id_q <= '0;
			entry_value_q <= '0;
		end else begin
			phase_q <= phase_nx;
			if (take) begin
				case (phase_q)
					h2d_pkg::PH_PREFACE: begin
						preface_bad_q <= bad_n;
						preface_pos_q <= preface_pos_q + 5'd1;
						if (preface_pos_q == 5'(h2d_pkg::PrefaceBytes - 1)) begin
							preface_pos_q <= '0;
							preface_bad_q <= 1'b0;
						end
					end
					h2d_pkg::PH_HEADER: begin
						header_pos_q <= header_pos_q == 4'd8 ? 4'd0 : header_pos_q + 4'd1;
						case (header_pos_q)
							4'd0: cur_length_q <= {in_byte, 16'd0};
							4'd1: cur_length_q[15:8] <= in_byte;
							4'd2: cur_length_q[7:0] <= in_byte;
							4'd3: cur_type_q <= in_byte;
							4'd4: cur_flags_q <= in_byte;
							4'd5: cur_stream_q <= {in_byte[6:0], 24'd0};
							4'd6: cur_stream_q[23:16] <= in_byte;
							4'd7: cur_stream_q[15:8] <= in_byte;
							default: begin
								cur_stream_q[7:0] <= in_byte;
								payload_pos_q <= '0;
								entry_pos_q <= '0;
								entry_id_q <= '0;
								entry_value_q <= '0;
								if (cmd.event_res < 4'(h2d_pkg::EV_TOO_LONG) &&
									cur_type_q == h2d_pkg::TypeHeaders)
									header_stream_q <= strm_n;
							end
						endcase
					end
					h2d_pkg::PH_PAYLOAD: begin
						payload_pos_q <= pp_n;
						if (is_set) begin
							if (entry_pos_q == 3'd5) begin
								entry_pos_q <= '0;
								entry_id_q <= '0;
								entry_value_q <= '0;
							end else begin
								entry_pos_q <= entry_pos_q + 3'd1;
								if (entry_pos_q < 3'd2) entry_id_q <= {entry_id_q[7:0], in_byte};
								else entry_value_q <= cmd.entry_value;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	property p_dead_stays;
		@(posedge clk) disable iff (!arst_n)
		phase_q == h2d_pkg::PH_DEAD |=> phase_q == h2d_pkg::PH_DEAD;
	endproperty
	a_dead_stays: assert property (p_dead_stays) else $error("left dead state");
	a_dead_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == h2d_pkg::PH_DEAD |-> !cmd.emit) else $error("dead emits");
	a_hdr_pos: assert property (@(posedge clk) disable iff (!arst_n)
		header_pos_q <= 4'd8) else $error("header position overrun");
	a_entry_pos: assert property (@(posedge clk) disable iff (!arst_n)
		entry_pos_q <= 3'd5) else $error("entry position overrun");

endmodule

### rtl/core/h2d_back.sv
// Back end: command queue, settings registers and output register.
module h2d_back #(
	parameter int Depth = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  h2d_pkg::cmd_t cmd,
	output logic          q_full,
	h2d_out_if.source     res
);

	localparam int Aw = $clog2(Depth);

	h2d_pkg::cmd_t mem_q [Depth];
	logic [Aw-1:0] wp_q, rp_q;
	logic [Aw:0]   cnt_q;
	logic          pop, push;
	h2d_pkg::cmd_t head;
	logic [31:0]   pend_str_q, pend_win_q, max_str_q, win_q;
	logic          pend_str_set_q, pend_win_set_q;
	logic [31:0]   max_str_n, win_n;
	logic          ovalid_q;

	// Settings side effects ride in the queue with the words, so the
	// committed values appear exactly on the word that commits them.
	assign push = cmd.emit || cmd.set_entry || cmd.clear_pending || cmd.commit;
	assign q_full = cnt_q == (Aw+1)'(Depth);
	assign head = mem_q[rp_q];
	assign pop = cnt_q != '0 && (!head.emit || !ovalid_q || res.ready);

	// The entry closed by the last payload byte counts in its own commit.
	always_comb begin
		max_str_n = max_str_q;
		win_n = win_q;
		if (head.commit) begin
			if (head.set_entry && head.entry_id == h2d_pkg::SetMaxStreams)
				max_str_n = head.entry_value;
			else if (pend_str_set_q) max_str_n = pend_str_q;
			if (head.set_entry && head.entry_id == h2d_pkg::SetWindow)
				win_n = head.entry_value;
			else if (pend_win_set_q) win_n = pend_win_q;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
			ovalid_q <= 1'b0;
			pend_str_set_q <= 1'b0;
			pend_win_set_q <= 1'b0;
			pend_str_q <= '0;
			pend_win_q <= '0;
			max_str_q <= h2d_pkg::MaxStreamsRst;
			win_q <= h2d_pkg::WindowRst;
		end else begin
			if (push) wp_q <= wp_q == Aw'(Depth - 1) ? '0 : wp_q + Aw'(1);
			if (pop) rp_q <= rp_q == Aw'(Depth - 1) ? '0 : rp_q + Aw'(1);
			cnt_q <= cnt_q + (Aw+1)'(push) - (Aw+1)'(pop);
			if (res.ready) ovalid_q <= 1'b0;
			if (pop) begin
				if (head.set_entry) begin
					if (head.entry_id == h2d_pkg::SetMaxStreams) begin
						pend_str_q <= head.entry_value;
						pend_str_set_q <= 1'b1;
					end else if (head.entry_id == h2d_pkg::SetWindow) begin
						pend_win_q <= head.entry_value;
						pend_win_set_q <= 1'b1;
					end
				end
				if (head.clear_pending) begin
					pend_str_set_q <= 1'b0;
					pend_win_set_q <= 1'b0;
				end
				max_str_q <= max_str_n;
				win_q <= win_n;
				if (head.emit) begin
					ovalid_q <= 1'b1;
					res.event_res <= head.event_res;
					res.frame_type <= head.frame_type;
					res.frame_flags <= head.frame_flags;
					res.stream_id <= head.stream_id;
					res.frame_length <= head.frame_length;
					res.payload_valid <= head.payload_valid;
					res.payload_byte <= head.payload_byte;
					res.payload_offset <= head.payload_offset;
					res.peer_max_streams <= max_str_n;
					res.peer_window <= win_n;
				end
			end
		end
	end

	assign res.valid = ovalid_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push) else $error("queue overflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (Aw+1)'(Depth)) else $error("queue count out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && !res.ready |=> ovalid_q) else $error("result dropped");

endmodule

### rtl/core/http2_frame_deframer_top.sv
// Top level of the HTTP/2 receive deframer.
// Throughput: one byte per cycle while the result side keeps up.
// A byte's result word passes through the command queue and then the output
// register before it shows.
// A four-entry command queue lets the input run on while results stall.
// Reset (arst_n low) returns to preface matching with default settings.
module http2_frame_deframer_top #(
	parameter int QueueDepth = 4
) (
	input logic        clk,
	input logic        arst_n,
	h2d_in_if.sink     in_ch,
	h2d_cfg_if.sink    cfg,
	h2d_out_if.source  out_ch
);

	logic [14:0]   max_frame_len_q;
	logic          take;
	logic          q_full;
	h2d_pkg::cmd_t cmd;

	assign cfg.ready = 1'b1;
	assign in_ch.ready = !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_frame_len_q <= 15'(h2d_pkg::FrameLimit);
		else if (cfg.valid) max_frame_len_q <= cfg.max_frame_len;
	end

	h2d_front u_front (
		.clk, .arst_n,
		.in_valid(in_ch.valid),
		.in_byte(in_ch.data_byte),
		.max_frame_len(max_frame_len_q),
		.take,
		.q_full,
		.cmd
	);

	h2d_back #(.Depth(QueueDepth)) u_back (
		.clk, .arst_n,
		.cmd,
		.q_full,
		.res(out_ch)
	);

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		take == (in_ch.valid && in_ch.ready)) else $error("accept mismatch");

endmodule

### verif/http2_frame_deframer_top_tb.sv
// Self-checking testbench of the HTTP/2 receive deframer: bytes in, checked words out.
module http2_frame_deframer_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 2000000;

	typedef struct packed {
		logic [3:0]  event_res;
		logic [7:0]  frame_type;
		logic [7:0]  frame_flags;
		logic [30:0] stream_id;
		logic [23:0] frame_length;
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic [13:0] payload_offset;
		logic [31:0] peer_max_streams;
		logic [31:0] peer_window;
	} deframe_word_t;

	localparam logic [7:0] PrefaceText [h2d_pkg::PrefaceBytes] = '{
		8'h50, 8'h52, 8'h49, 8'h20, 8'h2A, 8'h20, 8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h32,
		8'h2E, 8'h30, 8'h0D, 8'h0A, 8'h0D, 8'h0A, 8'h53, 8'h4D, 8'h0D, 8'h0A, 8'h0D, 8'h0A};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	h2d_in_if  in_ch();
	h2d_cfg_if cfg();
	h2d_out_if out_ch();

	http2_frame_deframer_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.cfg(cfg),
		.out_ch(out_ch)
	);

	always #5 clk = ~clk;

	logic [7:0]    rx_bytes[$];
	deframe_word_t expected_words[$];
	int            mismatches = 0;
	int            cycles = 0;
	bit            quiet_in = 1'b0;
	bit            quiet_out = 1'b0;

	// Tracking state of the deframer, advanced once per accepted byte.
	h2d_pkg::phase_t trk_phase = h2d_pkg::PH_PREFACE;
	int          trk_pre_pos = 0;
	bit          trk_pre_bad = 1'b0;
	int          trk_hdr_pos = 0;
	logic [23:0] trk_len = '0;
	logic [7:0]  trk_type = '0;
	logic [7:0]  trk_flags = '0;
	logic [30:0] trk_stream = '0;
	logic [14:0] trk_pay_pos = '0;
	logic [30:0] trk_hdr_stream = '0;
	int          trk_ent_pos = 0;
	logic [15:0] trk_ent_id = '0;
	logic [31:0] trk_ent_val = '0;
	logic [31:0] trk_pend_streams = '0;
	bit          trk_pend_streams_set = 1'b0;
	logic [31:0] trk_pend_window = '0;
	bit          trk_pend_window_set = 1'b0;
	logic [31:0] trk_max_streams = h2d_pkg::MaxStreamsRst;
	logic [31:0] trk_window = h2d_pkg::WindowRst;
	logic [14:0] trk_limit = 15'd16384;

	function automatic int pick_gap(bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void emit_word(logic [3:0] ev, bit hdr, bit pv, logic [7:0] pb,
		logic [13:0] po);
		deframe_word_t w;
		w.event_res = ev;
		w.frame_type = hdr ? trk_type : 8'd0;
		w.frame_flags = hdr ? trk_flags : 8'd0;
		w.stream_id = hdr ? trk_stream : 31'd0;
		w.frame_length = hdr ? trk_len : 24'd0;
		w.payload_valid = pv;
		w.payload_byte = pv ? pb : 8'd0;
		w.payload_offset = pv ? po : 14'd0;
		w.peer_max_streams = trk_max_streams;
		w.peer_window = trk_window;
		expected_words.push_back(w);
	endfunction

	// Frame-end action; a SETTINGS frame without ACK commits only on whole entries.
	function automatic logic [3:0] frame_end_action();
		case (trk_type)
			h2d_pkg::TypeSettings: begin
				if (trk_flags[0])
					return h2d_pkg::EV_ACK_SEEN;
				if (trk_len % 6 == 0) begin
					if (trk_pend_streams_set)
						trk_max_streams = trk_pend_streams;
					if (trk_pend_window_set)
						trk_window = trk_pend_window;
				end
				return h2d_pkg::EV_SETTINGS_ACK;
			end
			h2d_pkg::TypeHeaders, h2d_pkg::TypeCont: begin
				if (trk_flags[2])
					return trk_flags[0] ? h2d_pkg::EV_HDRS_RESP : h2d_pkg::EV_HDRS_DONE;
				return h2d_pkg::EV_FRAME_DONE;
			end
			h2d_pkg::TypePing:
				return trk_flags[0] ? h2d_pkg::EV_FRAME_DONE : h2d_pkg::EV_PONG;
			default: return h2d_pkg::EV_FRAME_DONE;
		endcase
	endfunction

	function automatic void track_byte(logic [7:0] b);
		logic [14:0] lim;
		logic [13:0] off;
		logic [3:0]  ev;
		case (trk_phase)
			h2d_pkg::PH_PREFACE: begin
				if (b != PrefaceText[trk_pre_pos])
					trk_pre_bad = 1'b1;
				trk_pre_pos++;
				if (trk_pre_pos == h2d_pkg::PrefaceBytes) begin
					trk_pre_pos = 0;
					trk_phase = trk_pre_bad ? h2d_pkg::PH_DEAD : h2d_pkg::PH_HEADER;
					emit_word(trk_pre_bad ? h2d_pkg::EV_BAD_PREFACE : h2d_pkg::EV_PREFACE_OK,
						1'b0, 1'b0, 8'd0, 14'd0);
				end
			end
			h2d_pkg::PH_HEADER: begin
				case (trk_hdr_pos)
					0: trk_len[23:16] = b;
					1: trk_len[15:8] = b;
					2: trk_len[7:0] = b;
					3: trk_type = b;
					4: trk_flags = b;
					5: trk_stream[30:24] = b[6:0];
					6: trk_stream[23:16] = b;
					7: trk_stream[15:8] = b;
					default: trk_stream[7:0] = b;
				endcase
				trk_hdr_pos++;
				if (trk_hdr_pos == 9) begin
					trk_hdr_pos = 0;
					trk_pay_pos = '0;
					trk_ent_pos = 0;
					trk_ent_id = '0;
					trk_ent_val = '0;
					trk_pend_streams = '0;
					trk_pend_streams_set = 1'b0;
					trk_pend_window = '0;
					trk_pend_window_set = 1'b0;
					lim = trk_limit > h2d_pkg::FrameLimit ? 15'(h2d_pkg::FrameLimit) : trk_limit;
					if (trk_len > lim) begin
						trk_phase = h2d_pkg::PH_DEAD;
						emit_word(h2d_pkg::EV_TOO_LONG, 1'b1, 1'b0, 8'd0, 14'd0);
					end else if (trk_type == h2d_pkg::TypeHeaders && trk_stream == 0) begin
						trk_phase = h2d_pkg::PH_DEAD;
						emit_word(h2d_pkg::EV_HDRS_ZERO, 1'b1, 1'b0, 8'd0, 14'd0);
					end else if (trk_type == h2d_pkg::TypeCont && trk_stream != trk_hdr_stream)
					begin
						trk_phase = h2d_pkg::PH_DEAD;
						emit_word(h2d_pkg::EV_CONT_MISM, 1'b1, 1'b0, 8'd0, 14'd0);
					end else if (trk_type == h2d_pkg::TypePing && trk_len != 8) begin
						trk_phase = h2d_pkg::PH_DEAD;
						emit_word(h2d_pkg::EV_BAD_PING, 1'b1, 1'b0, 8'd0, 14'd0);
					end else begin
						if (trk_type == h2d_pkg::TypeHeaders)
							trk_hdr_stream = trk_stream;
						if (trk_len == 0)
							emit_word(frame_end_action(), 1'b1, 1'b0, 8'd0, 14'd0);
						else
							trk_phase = h2d_pkg::PH_PAYLOAD;
					end
				end
			end
			h2d_pkg::PH_PAYLOAD: begin
				off = trk_pay_pos[13:0];
				ev = h2d_pkg::EV_PAYLOAD;
				if (trk_type == h2d_pkg::TypeSettings && !trk_flags[0]) begin
					if (trk_ent_pos < 2)
						trk_ent_id = {trk_ent_id[7:0], b};
					else
						trk_ent_val = {trk_ent_val[23:0], b};
					trk_ent_pos++;
					if (trk_ent_pos == 6) begin
						if (trk_ent_id == h2d_pkg::SetMaxStreams) begin
							trk_pend_streams = trk_ent_val;
							trk_pend_streams_set = 1'b1;
						end else if (trk_ent_id == h2d_pkg::SetWindow) begin
							trk_pend_window = trk_ent_val;
							trk_pend_window_set = 1'b1;
						end
						trk_ent_pos = 0;
						trk_ent_id = '0;
						trk_ent_val = '0;
					end
				end
				trk_pay_pos = trk_pay_pos + 15'd1;
				if (trk_pay_pos >= trk_len) begin
					trk_phase = h2d_pkg::PH_HEADER;
					ev = frame_end_action();
				end
				emit_word(ev, 1'b1, 1'b1, b, off);
			end
			default: ;
		endcase
	endfunction

	// Byte driver: each byte stays on the bus until it is taken.
	int in_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data_byte <= 8'd0;
			in_gap <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				track_byte(in_ch.data_byte);
			if (!in_ch.valid || in_ch.ready) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_ch.valid <= 1'b0;
				end else if (rx_bytes.size() > 0) begin
					in_ch.valid <= 1'b1;
					in_ch.data_byte <= rx_bytes.pop_front();
					in_gap <= pick_gap(quiet_in);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure.
	int out_stall = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			out_stall <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				deframe_word_t got;
				deframe_word_t want;
				got = '{out_ch.event_res, out_ch.frame_type, out_ch.frame_flags,
					out_ch.stream_id, out_ch.frame_length, out_ch.payload_valid,
					out_ch.payload_byte, out_ch.payload_offset, out_ch.peer_max_streams,
					out_ch.peer_window};
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word: %p", got);
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p, actual %p", want, got);
					end
				end
			end
			if (out_stall > 0) begin
				out_stall <= out_stall - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				out_stall <= pick_gap(quiet_out);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("[http2_frame_deframer_top] ERROR");
			$finish;
		end
	end

	// Generator-side view of the limit and of the last HEADERS stream.
	int          gen_limit = 16384;
	logic [30:0] gen_hdr_stream = '0;
	int          random_sent = 0;

	task automatic push_frame(int len, logic [7:0] ftype, logic [7:0] flags, logic [31:0] sid,
		logic [7:0] body[$]);
		logic [23:0] l;
		l = 24'(len);
		rx_bytes.push_back(l[23:16]);
		rx_bytes.push_back(l[15:8]);
		rx_bytes.push_back(l[7:0]);
		rx_bytes.push_back(ftype);
		rx_bytes.push_back(flags);
		rx_bytes.push_back(sid[31:24]);
		rx_bytes.push_back(sid[23:16]);
		rx_bytes.push_back(sid[15:8]);
		rx_bytes.push_back(sid[7:0]);
		foreach (body[i])
			rx_bytes.push_back(body[i]);
		if (ftype == h2d_pkg::TypeHeaders)
			gen_hdr_stream = sid[30:0];
	endtask

	task automatic push_plain(int len, logic [7:0] ftype, logic [7:0] flags, logic [31:0] sid);
		logic [7:0] body[$];
		for (int i = 0; i < len; i++)
			body.push_back(8'($urandom));
		push_frame(len, ftype, flags, sid, body);
	endtask

	// SETTINGS body of whole entries, optionally with a trailing partial entry.
	task automatic push_settings(int entries, int partial, logic [7:0] flags);
		logic [7:0]  body[$];
		logic [15:0] id;
		logic [31:0] val;
		int          r;
		for (int e = 0; e < entries; e++) begin
			r = $urandom_range(0, 2);
			id = r == 0 ? h2d_pkg::SetMaxStreams : r == 1 ? h2d_pkg::SetWindow :
				16'($urandom);
			val = $urandom;
			body.push_back(id[15:8]);
			body.push_back(id[7:0]);
			for (int k = 3; k >= 0; k--)
				body.push_back(val[k*8 +: 8]);
		end
		for (int k = 0; k < partial; k++)
			body.push_back(8'($urandom));
		push_frame(entries * 6 + partial, h2d_pkg::TypeSettings, flags,
			{$urandom} & 32'h8000_0000, body);
	endtask

	function automatic logic [31:0] rand_stream();
		logic [31:0] s;
		s = $urandom;
		if (s[30:0] == 0)
			s[0] = 1'b1;
		return s;
	endfunction

	task automatic push_random_frame();
		int r;
		int len;
		int cap;
		logic [7:0] t;
		r = $urandom_range(0, 99);
		cap = gen_limit < 24 ? gen_limit : 24;
		len = $urandom_range(0, 19) == 0 ? $urandom_range(0, gen_limit < 400 ? gen_limit : 400)
			: $urandom_range(0, cap);
		if (r < 25) begin
			if ($urandom_range(0, 4) == 0)
				push_plain(len, h2d_pkg::TypeSettings, 8'($urandom) | h2d_pkg::FlagAck,
					$urandom);
			else begin
				cap = gen_limit < 36 ? gen_limit : 36;
				len = $urandom_range(0, cap);
				if ($urandom_range(0, 3) == 0)
					push_settings(len / 6, len % 6, 8'($urandom) & ~h2d_pkg::FlagAck);
				else
					push_settings(len / 6, 0, 8'($urandom) & ~h2d_pkg::FlagAck);
			end
		end else if (r < 40)
			push_plain(len, h2d_pkg::TypeHeaders, 8'($urandom), rand_stream());
		else if (r < 50)
			push_plain(len, h2d_pkg::TypeCont, 8'($urandom), {1'($urandom), gen_hdr_stream});
		else if (r < 60 && gen_limit >= 8)
			push_plain(8, h2d_pkg::TypePing, 8'($urandom), $urandom);
		else begin
			do
				t = 8'($urandom);
			while (t == h2d_pkg::TypeHeaders || t == h2d_pkg::TypeCont ||
				t == h2d_pkg::TypePing || t == h2d_pkg::TypeSettings);
			push_plain(len, t, 8'($urandom), $urandom);
		end
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (rx_bytes.size() != 0 || in_ch.valid || expected_words.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_limit(logic [14:0] value);
		wait_idle();
		cfg.valid <= 1'b1;
		cfg.max_frame_len <= value;
		do
			@(posedge clk);
		while (!(cfg.valid && cfg.ready));
		trk_limit = value;
		gen_limit = value > h2d_pkg::FrameLimit ? h2d_pkg::FrameLimit : int'(value);
		cfg.valid <= 1'b0;
	endtask

	task automatic random_phase(int bytes);
		int start;
		start = random_sent;
		quiet_in = $urandom_range(0, 3) == 0;
		quiet_out = $urandom_range(0, 3) == 0;
		while (random_sent - start < bytes) begin
			int before_size;
			before_size = rx_bytes.size();
			push_random_frame();
			random_sent += rx_bytes.size() - before_size;
		end
	endtask

	initial begin
		int kind;
		in_ch.valid = 1'b0;
		in_ch.data_byte = 8'd0;
		cfg.valid = 1'b0;
		cfg.max_frame_len = 15'd0;
		out_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (PrefaceText[i])
			rx_bytes.push_back(PrefaceText[i]);
		// Directed frames: a CONTINUATION on stream 0 is legal before any HEADERS.
		push_plain(0, h2d_pkg::TypeCont, h2d_pkg::FlagEndHdrs, 32'h8000_0000);
		push_plain(0, h2d_pkg::TypeSettings, h2d_pkg::FlagAck, 32'h0);
		push_settings(3, 0, 8'h00);
		push_settings(1, 2, 8'h00);
		push_settings(0, 0, 8'h00);
		push_plain(8, h2d_pkg::TypePing, 8'h00, 32'h0);
		push_plain(8, h2d_pkg::TypePing, h2d_pkg::FlagAck, 32'h0);
		push_plain(3, h2d_pkg::TypeHeaders, 8'h00, 32'h7FFF_FFFF);
		push_plain(2, h2d_pkg::TypeCont, h2d_pkg::FlagEndHdrs, 32'h7FFF_FFFF);
		push_plain(1, h2d_pkg::TypeHeaders, h2d_pkg::FlagEndHdrs | h2d_pkg::FlagEndStrm,
			32'h0000_0001);
		push_plain(0, h2d_pkg::TypeHeaders, h2d_pkg::FlagEndHdrs, 32'h8000_0005);
		push_plain(0, 8'h00, 8'hFF, 32'h0);
		push_plain(5, 8'hFF, 8'h00, 32'hFFFF_FFFF);

		write_limit(15'd0);
		random_phase(60);
		write_limit(15'h7FFF);
		push_plain(40, 8'h00, 8'h00, 32'h0);
		random_phase(120);
		write_limit(15'($urandom_range(50, 120)));
		// A frame of exactly the limit is still accepted.
		push_plain(gen_limit, 8'h00, 8'h00, 32'h0000_0007);
		random_phase(150);
		write_limit(15'd16384);
		random_phase(150);

		// One fatal frame at the end, then bytes that a dead block must ignore.
		kind = $urandom_range(0, 3);
		case (kind)
			0: push_plain(0, 8'($urandom), 8'($urandom), {$urandom} & 32'h00FF_FFFF);
			1: push_plain(0, h2d_pkg::TypeHeaders, 8'($urandom), {$urandom} & 32'h8000_0000);
			2: push_plain(0, h2d_pkg::TypeCont, 8'($urandom), {1'b0, gen_hdr_stream + 31'd1});
			default: push_plain($urandom_range(0, 1) ? 0 : 9, h2d_pkg::TypePing,
				8'($urandom), 32'h0);
		endcase
		if (kind == 0) begin
			// Replace the length bytes with an oversized value.
			logic [23:0] big;
			big = $urandom_range(0, 1) ? 24'hFFFFFF : 24'($urandom_range(16385, 24'hFFFFFF));
			rx_bytes[rx_bytes.size() - 9] = big[23:16];
			rx_bytes[rx_bytes.size() - 8] = big[15:8];
			rx_bytes[rx_bytes.size() - 7] = big[7:0];
		end
		for (int i = 0; i < 20; i++)
			rx_bytes.push_back(8'($urandom));

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_words.size() == 0)
			$display("[http2_frame_deframer_top] OK");
		else
			$display("[http2_frame_deframer_top] ERROR");
		$finish;
	end

endmodule

### filelist.f
rtl/core/h2d_pkg.sv
rtl/core/h2d_if.sv
rtl/core/h2d_front.sv
rtl/core/h2d_back.sv
rtl/core/http2_frame_deframer_top.sv
verif/http2_frame_deframer_top_tb.sv
